// ===== hdl/lpd_pkg.sv =====
`default_nettype none
package lpd_pkg;

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_EMPTY   = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // error codes
   localparam logic [2:0] ERR_BAD_HEADER = 3'd0;
   localparam logic [2:0] ERR_BAD_PREFIX = 3'd1;
   localparam logic [2:0] ERR_BAD_LENGTH = 3'd2;
   localparam logic [2:0] ERR_TOO_LARGE  = 3'd3;
   localparam logic [2:0] ERR_OVERFLOW   = 3'd4;

   // register indexes
   localparam logic [7:0] REG_PAYLOAD_CAP  = 8'd0;
   localparam logic [7:0] REG_HEADER_LIMIT = 8'd1;

   localparam logic [15:0] PAYLOAD_CAP_RESET  = 16'd4096;
   localparam logic [7:0]  HEADER_LIMIT_RESET = 8'd100;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   // length accumulator holds up to payload_cap + 1
   localparam int LEN_W = 17;

   typedef struct packed {
      logic             prefix_ok;
      logic             number_ok;
      logic             negative;
      logic [LEN_W-1:0] length;
   } hdr_status_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
      logic [2:0] error_code;
   } rsp_type;

endpackage
`default_nettype wire

// ===== hdl/lpd_parse.sv =====
`default_nettype none
module lpd_parse (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   byte_en,
   input  wire logic                   restart,
   input  wire logic [7:0]             rx_byte,
   input  wire logic [15:0]            payload_cap,
   output lpd_pkg::hdr_status_type     status
);

   typedef enum logic [3:0] {
      ST_L, ST_E, ST_N, ST_COLON, ST_START, ST_SPACE, ST_SIGN,
      ST_DIGITS, ST_ENDED, ST_BADPREFIX, ST_BADNUM
   } stage_type;

   localparam logic [7:0] CHAR_L     = 8'h4C;
   localparam logic [7:0] CHAR_E     = 8'h45;
   localparam logic [7:0] CHAR_N     = 8'h4E;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   stage_type                   stage_ff, stage_in;
   logic [lpd_pkg::LEN_W-1:0]   length_ff, length_in;
   logic                        negative_ff, negative_in;

   logic                        is_space, is_digit;
   logic [lpd_pkg::LEN_W-1:0]   max_ext;
   logic [lpd_pkg::LEN_W+3:0]   times_ten;
   logic [lpd_pkg::LEN_W+3:0]   grown;
   logic [lpd_pkg::LEN_W-1:0]   digit_len;

   assign is_space = (rx_byte == 8'h20) || (rx_byte == 8'h09) || (rx_byte == 8'h0B) ||
                     (rx_byte == 8'h0C) || (rx_byte == 8'h0D);
   assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);

   // saturating decimal step: x*10 + digit, clamped to payload_cap + 1
   always_comb begin
      max_ext   = {1'b0, payload_cap};
      times_ten = {length_ff, 3'b000} + {2'b00, length_ff, 1'b0}
                + {(lpd_pkg::LEN_W+4)'(rx_byte[3:0])};
      if (length_ff <= max_ext) begin
         grown = times_ten;
      end else begin
         grown = {4'b0000, length_ff};
      end
      if (grown > {4'b0000, max_ext}) begin
         digit_len = max_ext + 1'b1;
      end else begin
         digit_len = grown[lpd_pkg::LEN_W-1:0];
      end
   end

   always_comb begin
      stage_in    = stage_ff;
      length_in   = length_ff;
      negative_in = negative_ff;
      case (stage_ff)
         ST_L:     stage_in = (rx_byte == CHAR_L)     ? ST_E     : ST_BADPREFIX;
         ST_E:     stage_in = (rx_byte == CHAR_E)     ? ST_N     : ST_BADPREFIX;
         ST_N:     stage_in = (rx_byte == CHAR_N)     ? ST_COLON : ST_BADPREFIX;
         ST_COLON: stage_in = (rx_byte == CHAR_COLON) ? ST_START : ST_BADPREFIX;
         ST_START, ST_SPACE: begin
            if (is_space) begin
               stage_in = ST_SPACE;
            end else if (rx_byte == CHAR_PLUS || rx_byte == CHAR_MINUS) begin
               negative_in = (rx_byte == CHAR_MINUS);
               stage_in    = ST_SIGN;
            end else if (is_digit) begin
               length_in = digit_len;
               stage_in  = ST_DIGITS;
            end else begin
               stage_in = ST_BADNUM;
            end
         end
         ST_SIGN: begin
            if (is_digit) begin
               length_in = digit_len;
               stage_in  = ST_DIGITS;
            end else begin
               stage_in = ST_BADNUM;
            end
         end
         ST_DIGITS: begin
            if (is_digit) begin
               length_in = digit_len;
            end else if (rx_byte == CHAR_NUL) begin
               stage_in = ST_ENDED;
            end else begin
               stage_in = ST_BADNUM;
            end
         end
         default: stage_in = stage_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         stage_ff    <= ST_L;
         length_ff   <= '0;
         negative_ff <= 1'b0;
      end else if (byte_en) begin
         stage_ff    <= stage_in;
         length_ff   <= length_in;
         negative_ff <= negative_in;
      end
   end

   always_comb begin
      status.prefix_ok = !(stage_ff inside {ST_L, ST_E, ST_N, ST_COLON, ST_BADPREFIX});
      status.number_ok = (stage_ff == ST_DIGITS) || (stage_ff == ST_ENDED);
      status.negative  = negative_ff;
      status.length    = length_ff;
   end

endmodule
`default_nettype wire

// ===== hdl/lpd_out_reg.sv =====
`default_nettype none
module lpd_out_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire lpd_pkg::rsp_type result,
   input  wire logic             rsp_stall,
   output logic                  free,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_data,
   output logic                  rsp_last,
   output logic [2:0]            rsp_error_code
);

   logic             valid_ff;
   lpd_pkg::rsp_type result_ff;

   // slot frees up in the same cycle the receiver takes the item
   assign free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (free) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (free && load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = result_ff.kind;
   assign rsp_data       = result_ff.data;
   assign rsp_last       = result_ff.last;
   assign rsp_error_code = result_ff.error_code;

endmodule
`default_nettype wire

// ===== hdl/length_prefixed_deframer.sv =====
`default_nettype none
// length-prefixed deframer
//
// req channel: one received byte per item (req_rx_byte), valid/stall handshake.
// the stream carries frames of the form "LEN:<decimal>\n" followed by exactly
// that many payload bytes. rsp channel: at most one item per received byte:
// a payload byte (last set on the final byte of a frame), an empty frame for
// a zero length, or an error with its code when a header line ends badly.
// header bytes and the newline of a good header give no rsp item.
// csr channel: write-only, valid/ready, index 0 payload length cap, index 1
// header_limit. ready is always high; write only while the block is idle.
// a req item is taken into the input register at acceptance; its result is
// then loaded into the result register, which drives rsp_valid, once it is free.
// throughput: one byte per clock while no stalled result blocks it, since the
// header parser and frame counters update once per byte.
// while rsp_stall holds a result, bytes that make no result still pass
// through; the next byte that makes one waits in the input register with
// req_stall high. reset clears all control state and loads the register defaults
// (4096 and 100). once a frame would hold BUFFER_BYTES bytes an overflow
// error is sent and every later byte is dropped until reset.
module length_prefixed_deframer #(
   parameter int BUFFER_BYTES = 8192
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input bytes
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   // results
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_data,
   output logic             rsp_last,
   output logic [2:0]       rsp_error_code,
   // register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   // held byte count never goes past BUFFER_BYTES - 1
   localparam int CW = $clog2(BUFFER_BYTES);
   localparam logic [CW-1:0] HELD_LIMIT = CW'(BUFFER_BYTES - 1);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PAYLOAD,
      PH_DEAD
   } phase_type;

   // configuration
   logic [15:0] payload_cap_ff;
   logic [7:0]  header_limit_ff;

   // input register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;

   // frame state
   phase_type   phase_ff, phase_in;
   logic [CW-1:0] held_ff, held_in;
   logic [15:0] remaining_ff, remaining_in;

   lpd_pkg::hdr_status_type hdr;
   lpd_pkg::rsp_type        result;
   logic                    has_result;
   logic                    parse_en;
   logic                    parse_restart;
   logic                    out_free;
   logic                    advance;
   logic [lpd_pkg::LEN_W-1:0] max_ext;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         payload_cap_ff  <= lpd_pkg::PAYLOAD_CAP_RESET;
         header_limit_ff <= lpd_pkg::HEADER_LIMIT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            lpd_pkg::REG_PAYLOAD_CAP:  payload_cap_ff  <= csr_wdata;
            lpd_pkg::REG_HEADER_LIMIT: header_limit_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // the byte in the input register moves on when its result has a place,
   // or when it makes no result at all
   assign advance   = in_valid_ff && (out_free || !has_result);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   lpd_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .byte_en     (parse_en),
      .restart     (parse_restart),
      .rx_byte     (in_byte_ff),
      .payload_cap (payload_cap_ff),
      .status      (hdr)
   );

   assign max_ext = {1'b0, payload_cap_ff};

   // per-byte frame control
   always_comb begin
      phase_in          = phase_ff;
      held_in           = held_ff;
      remaining_in      = remaining_ff;
      has_result        = 1'b0;
      parse_en          = 1'b0;
      parse_restart     = 1'b0;
      result.kind       = lpd_pkg::KIND_ERROR;
      result.data       = 8'h00;
      result.last       = 1'b0;
      result.error_code = lpd_pkg::ERR_BAD_HEADER;
      case (phase_ff)
         PH_HEADER, PH_PAYLOAD: begin
            if (held_ff >= HELD_LIMIT) begin
               // frame would fill the buffer: report once and go dead
               has_result        = 1'b1;
               result.error_code = lpd_pkg::ERR_OVERFLOW;
               phase_in          = PH_DEAD;
            end else if (phase_ff == PH_PAYLOAD) begin
               has_result   = 1'b1;
               result.kind  = lpd_pkg::KIND_PAYLOAD;
               result.data  = in_byte_ff;
               remaining_in = remaining_ff - 1'b1;
               if (remaining_ff == 16'd1) begin
                  result.last   = 1'b1;
                  phase_in      = PH_HEADER;
                  held_in       = '0;
                  parse_restart = 1'b1;
               end else begin
                  held_in = held_ff + 1'b1;
               end
            end else if (in_byte_ff == lpd_pkg::CHAR_NEWLINE) begin
               // header line complete: checks in priority order
               has_result    = 1'b1;
               parse_restart = 1'b1;
               held_in       = '0;
               if (held_ff == '0 || held_ff >= CW'(header_limit_ff)) begin
                  result.error_code = lpd_pkg::ERR_BAD_HEADER;
               end else if (!hdr.prefix_ok) begin
                  result.error_code = lpd_pkg::ERR_BAD_PREFIX;
               end else if (!hdr.number_ok) begin
                  result.error_code = lpd_pkg::ERR_BAD_LENGTH;
               end else if (hdr.negative && hdr.length != '0) begin
                  result.error_code = lpd_pkg::ERR_BAD_LENGTH;
               end else if (hdr.length > max_ext) begin
                  result.error_code = lpd_pkg::ERR_TOO_LARGE;
               end else if (hdr.length == '0) begin
                  result.kind = lpd_pkg::KIND_EMPTY;
                  result.last = 1'b1;
               end else begin
                  // good nonzero length: header plus newline stay counted
                  has_result    = 1'b0;
                  parse_restart = 1'b0;
                  phase_in      = PH_PAYLOAD;
                  remaining_in  = hdr.length[15:0];
                  held_in       = held_ff + 1'b1;
               end
            end else begin
               parse_en = advance;
               held_in  = held_ff + 1'b1;
            end
         end
         default: ;
      endcase
      if (!advance) begin
         parse_restart = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         held_ff      <= '0;
         remaining_ff <= '0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         held_ff      <= held_in;
         remaining_ff <= remaining_in;
      end
   end

   lpd_out_reg u_out (
      .clock          (clock),
      .reset          (reset),
      .load           (advance && has_result),
      .result         (result),
      .rsp_stall      (rsp_stall),
      .free           (out_free),
      .rsp_valid      (rsp_valid),
      .rsp_kind       (rsp_kind),
      .rsp_data       (rsp_data),
      .rsp_last       (rsp_last),
      .rsp_error_code (rsp_error_code)
   );

endmodule
`default_nettype wire

// ===== hdl/lpd_checker.sv =====
`default_nettype none
module lpd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_kind,
   input wire logic [7:0] rsp_data,
   input wire logic       rsp_last,
   input wire logic [2:0] rsp_error_code
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_data)
         && $stable(rsp_last) && $stable(rsp_error_code))
      else $error("rsp item changed while stalled");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid right after reset");

   // payload fields are clean outside payload items
   a_non_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != lpd_pkg::KIND_PAYLOAD |-> rsp_data == 8'h00)
      else $error("data set on non-payload item");

   // error items carry a known code and no last mark; others carry no code
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == lpd_pkg::KIND_ERROR
                        && !rsp_last && rsp_error_code <= lpd_pkg::ERR_OVERFLOW)
                 || (rsp_kind == lpd_pkg::KIND_EMPTY && rsp_last
                        && rsp_error_code == lpd_pkg::ERR_BAD_HEADER)
                 || (rsp_kind == lpd_pkg::KIND_PAYLOAD
                        && rsp_error_code == lpd_pkg::ERR_BAD_HEADER))
      else $error("malformed rsp item");

endmodule

bind length_prefixed_deframer lpd_checker u_lpd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_kind       (rsp_kind),
   .rsp_data       (rsp_data),
   .rsp_last       (rsp_last),
   .rsp_error_code (rsp_error_code)
);
`default_nettype wire

// ===== sim/tb_length_prefixed_deframer.sv =====
`default_nettype none
module tb_length_prefixed_deframer;

   localparam int CLOCK_PERIOD       = 8;
   localparam int FRAME_BUFFER       = 8192;
   // two register stages inside the block, plus margin
   localparam int DRAIN_CYCLES       = 8;
   localparam int PRESSURE_CYCLES    = 300;
   localparam int RANDOM_PHASE_BYTES = 180;
   localparam int RUN_LIMIT_CYCLES   = 1000000;

   // index past the register map, the block must ignore it
   localparam logic [7:0] REG_UNUSED = 8'd2;
   // error_code field value on results that are not errors
   localparam logic [2:0] NO_ERROR   = 3'd0;

   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_VTAB      = 8'h0B;
   localparam logic [7:0] CHAR_FORM_FEED = 8'h0C;
   localparam logic [7:0] CHAR_CR        = 8'h0D;

   typedef enum logic [1:0] {FRAME_HEADER, FRAME_PAYLOAD, FRAME_DEAD} frame_phase_type;

   // header parser: prefix letters, then blanks, sign, digits
   typedef enum logic [3:0] {
      PS_L, PS_E, PS_N, PS_COLON, PS_START, PS_SPACE, PS_SIGN,
      PS_DIGITS, PS_ENDED, PS_BADPREFIX, PS_BADNUM
   } parse_stage_type;

   // tracks the frame state of the byte stream and the results it owes
   class frame_scoreboard;
      logic [15:0]      payload_cap;
      logic [7:0]       header_limit;
      frame_phase_type  phase;
      logic [12:0]      header_count;
      parse_stage_type  stage;
      logic [16:0]      length_value;
      logic             negative_seen;
      logic [15:0]      payload_remaining;
      lpd_pkg::rsp_type expected_q[$];
      int               mismatches;
      int               checked;

      function new();
         payload_cap  = lpd_pkg::PAYLOAD_CAP_RESET;
         header_limit = lpd_pkg::HEADER_LIMIT_RESET;
         mismatches   = 0;
         checked      = 0;
         restart_frame();
      endfunction

      function void restart_frame();
         phase             = FRAME_HEADER;
         header_count      = '0;
         stage             = PS_L;
         length_value      = '0;
         negative_seen     = 1'b0;
         payload_remaining = '0;
      endfunction

      function void write_reg(logic [7:0] index, logic [15:0] value);
         if (index == lpd_pkg::REG_PAYLOAD_CAP) begin
            payload_cap = value;
         end else if (index == lpd_pkg::REG_HEADER_LIMIT) begin
            header_limit = value[7:0];
         end
      endfunction

      function void push_result(logic [1:0] kind, logic [7:0] data, logic last,
                                logic [2:0] code);
         lpd_pkg::rsp_type r;
         r.kind       = kind;
         r.data       = data;
         r.last       = last;
         r.error_code = code;
         expected_q.push_back(r);
      endfunction

      // decimal accumulate, pinned at payload_cap + 1
      function void add_digit(logic [7:0] c);
         int v;
         v = length_value;
         if (v <= payload_cap) v = v * 10 + (c - 8'h30);
         if (v > payload_cap) v = payload_cap + 1;
         length_value = v[16:0];
      endfunction

      function void note_byte(logic [7:0] c);
         int         held;
         logic [2:0] code;
         if (phase == FRAME_DEAD) return;
         if (phase == FRAME_HEADER) held = header_count;
         else held = header_count + 1 + length_value - payload_remaining;
         if (held + 1 >= FRAME_BUFFER) begin
            push_result(lpd_pkg::KIND_ERROR, 8'h00, 1'b0, lpd_pkg::ERR_OVERFLOW);
            phase = FRAME_DEAD;
            return;
         end
         if (phase == FRAME_PAYLOAD) begin
            payload_remaining = payload_remaining - 1;
            push_result(lpd_pkg::KIND_PAYLOAD, c, payload_remaining == 0, NO_ERROR);
            if (payload_remaining == 0) restart_frame();
            return;
         end
         if (c != lpd_pkg::CHAR_NEWLINE) begin
            case (stage)
               PS_L:     stage = (c == "L") ? PS_E : PS_BADPREFIX;
               PS_E:     stage = (c == "E") ? PS_N : PS_BADPREFIX;
               PS_N:     stage = (c == "N") ? PS_COLON : PS_BADPREFIX;
               PS_COLON: stage = (c == ":") ? PS_START : PS_BADPREFIX;
               PS_START, PS_SPACE: begin
                  if (c == " " || c == CHAR_TAB || c == CHAR_VTAB ||
                      c == CHAR_FORM_FEED || c == CHAR_CR) begin
                     stage = PS_SPACE;
                  end else if (c == "+" || c == "-") begin
                     negative_seen = (c == "-");
                     stage = PS_SIGN;
                  end else if (c >= "0" && c <= "9") begin
                     add_digit(c);
                     stage = PS_DIGITS;
                  end else begin
                     stage = PS_BADNUM;
                  end
               end
               PS_SIGN: begin
                  if (c >= "0" && c <= "9") begin
                     add_digit(c);
                     stage = PS_DIGITS;
                  end else begin
                     stage = PS_BADNUM;
                  end
               end
               PS_DIGITS: begin
                  if (c >= "0" && c <= "9") add_digit(c);
                  else if (c == CHAR_NUL) stage = PS_ENDED;
                  else stage = PS_BADNUM;
               end
               default: ;
            endcase
            header_count = header_count + 1;
            return;
         end
         // newline closes the header, checks in priority order
         if (header_count == 0 || header_count >= header_limit) begin
            code = lpd_pkg::ERR_BAD_HEADER;
         end else if (stage <= PS_COLON || stage == PS_BADPREFIX) begin
            code = lpd_pkg::ERR_BAD_PREFIX;
         end else if (stage != PS_DIGITS && stage != PS_ENDED) begin
            code = lpd_pkg::ERR_BAD_LENGTH;
         end else if (negative_seen && length_value != 0) begin
            code = lpd_pkg::ERR_BAD_LENGTH;
         end else if (length_value > payload_cap) begin
            code = lpd_pkg::ERR_TOO_LARGE;
         end else if (length_value == 0) begin
            push_result(lpd_pkg::KIND_EMPTY, 8'h00, 1'b1, NO_ERROR);
            restart_frame();
            return;
         end else begin
            phase = FRAME_PAYLOAD;
            payload_remaining = length_value[15:0];
            return;
         end
         push_result(lpd_pkg::KIND_ERROR, 8'h00, 1'b0, code);
         restart_frame();
      endfunction

      function void check_result(lpd_pkg::rsp_type got);
         lpd_pkg::rsp_type want;
         checked++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] result %0d with none due: kind %0d data %02h last %0b code %0d",
                        $time, checked, got.kind, got.data, got.last, got.error_code);
            return;
         end
         want = expected_q.pop_front();
         if (got.kind !== want.kind || got.data !== want.data ||
             got.last !== want.last || got.error_code !== want.error_code) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("[%0t] result %0d differs: expected kind %0d data %02h last %0b code %0d",
                        $time, checked, want.kind, want.data, want.last, want.error_code);
               $display("   actual kind %0d data %02h last %0b code %0d",
                        got.kind, got.data, got.last, got.error_code);
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte    = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_data;
   logic        rsp_last;
   logic [2:0]  rsp_error_code;
   logic        csr_valid      = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index      = 8'h00;
   logic [15:0] csr_wdata      = 16'h0000;

   frame_scoreboard sb;
   // calm turns off idling on both sides for a phase
   bit          calm           = 1'b0;
   // set by the stimulus, picked up by the result side to start a long hold-off
   bit          hold_output    = 1'b0;
   int          byte_count     = 0;
   logic [7:0]  header_line[$];

   length_prefixed_deframer #(
      .BUFFER_BYTES   (FRAME_BUFFER)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_data       (rsp_data),
      .rsp_last       (rsp_last),
      .rsp_error_code (rsp_error_code),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // mostly back to back, sometimes a short gap, now and then a long gap
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // any byte except the header terminator
   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == lpd_pkg::CHAR_NEWLINE) b = CHAR_VTAB;
      return b;
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) header_line.push_back(s[i]);
   endfunction

   // offer one byte, hold it until the block takes it, then update the prediction
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(b);
      byte_count++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // random payload for whatever length the last header announced
   task automatic finish_frame();
      while (sb.phase == FRAME_PAYLOAD) send_byte(8'($urandom_range(0, 255)));
   endtask

   // stop offering, wait for all owed results, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // csr_valid drops after each write so back to back calls never collide
   task automatic write_csr(input logic [7:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(index, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] max_len, input logic [7:0] limit);
      settle();
      write_csr(lpd_pkg::REG_PAYLOAD_CAP, max_len);
      write_csr(lpd_pkg::REG_HEADER_LIMIT, limit);
   endtask

   // one header line (well-formed most of the time) plus its payload
   task automatic random_frame();
      int pick;
      int n;
      int r;
      header_line.delete();
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         add_text("LEN:");
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               case ($urandom_range(0, 4))
                  0: header_line.push_back(" ");
                  1: header_line.push_back(CHAR_TAB);
                  2: header_line.push_back(CHAR_VTAB);
                  3: header_line.push_back(CHAR_FORM_FEED);
                  default: header_line.push_back(CHAR_CR);
               endcase
            end
         end
         r = $urandom_range(0, 9);
         if (r == 0) header_line.push_back("+");
         else if (r == 1) header_line.push_back("-");
         if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) header_line.push_back("0");
         r = $urandom_range(0, 19);
         if (r == 18) begin
            // seven digits or more, always past any payload cap, so it saturates
            header_line.push_back(8'h30 + 8'($urandom_range(1, 9)));
            repeat ($urandom_range(6, 9)) header_line.push_back(8'h30 + 8'($urandom_range(0, 9)));
         end else begin
            if (r < 14) n = $urandom_range(0, 12);
            else if (r < 16) n = $urandom_range(13, 300);
            else if (r == 19) n = 0;
            else if (sb.payload_cap > 300) n = $urandom_range(0, 12);
            else n = sb.payload_cap + (r - 16);   // exactly at the cap or one past
            add_text($sformatf("%0d", n));
         end
         r = $urandom_range(0, 19);
         if (r < 2) begin
            // nul ends the number, trailing bytes up to the newline don't matter
            header_line.push_back(CHAR_NUL);
            repeat ($urandom_range(0, 3)) header_line.push_back(noise_byte());
         end else if (r == 2) begin
            header_line.push_back(noise_byte());
         end
      end else if (pick < 90) begin
         add_text("LEN:5");
         r = $urandom_range(0, 2);
         if (r == 0) begin
            header_line[$urandom_range(0, 3)] = noise_byte();
         end else if (r == 1) begin
            // cut short, down to an empty line
            n = $urandom_range(0, 3);
            while (header_line.size() > n) void'(header_line.pop_back());
         end else begin
            // padded to one short of header_limit or exactly at it
            n = int'(sb.header_limit) - 6 + int'($urandom_range(0, 1));
            void'(header_line.pop_back());
            repeat ((n < 0) ? 0 : n) header_line.push_back(" ");
            header_line.push_back("5");
         end
      end else begin
         repeat ($urandom_range(0, 20)) header_line.push_back(noise_byte());
      end
      header_line.push_back(lpd_pkg::CHAR_NEWLINE);
      foreach (header_line[i]) send_byte(header_line[i]);
      finish_frame();
   endtask

   // result side: check every accepted item, stall at random
   initial begin : result_sink
      int               stall_left;
      lpd_pkg::rsp_type got;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            got = {rsp_kind, rsp_data, rsp_last, rsp_error_code};
            sb.check_result(got);
         end
         // long hold-off so the block backs up into its input
         if (hold_output) begin
            hold_output = 1'b0;
            stall_left  = PRESSURE_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = calm ? 0 : pick_gap();
         end
      end
   end

   initial begin : stimulus
      int          mark;
      logic [15:0] max_len;
      logic [7:0]  limit;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed frames under the reset register values
      // payload extremes, including a newline byte inside the payload
      send_text("LEN:3\n");
      send_byte(CHAR_NUL);
      send_byte(8'hFF);
      send_byte(lpd_pkg::CHAR_NEWLINE);
      send_text("LEN:0\n");                   // empty frame
      send_text("\n");                        // empty header
      send_text("LEX:4\n");                   // wrong prefix letter
      send_text("LE\n");                      // prefix cut short
      send_text("LEN:\n");                    // no number at all
      // every blank, then a plus sign
      send_text("LEN: ");
      send_byte(CHAR_TAB);
      send_byte(CHAR_VTAB);
      send_byte(CHAR_FORM_FEED);
      send_byte(CHAR_CR);
      send_text("+2\n");
      finish_frame();
      send_text("LEN:-0\n");                  // minus zero is a plain zero
      send_text("LEN:-5\n");                  // negative
      send_text("LEN:-\n");                   // sign without digits
      send_text("LEN:2x\n");                  // junk after the digits
      // nul ends the number, the rest of the line is ignored
      send_text("LEN:2");
      send_byte(CHAR_NUL);
      send_text("zz");
      send_byte(CHAR_NUL);
      send_text("\n");
      finish_frame();
      send_text("LEN:");                      // nul before any digit
      send_byte(CHAR_NUL);
      send_text("2\n");
      send_text("LEN:4097\n");                // one past the payload cap
      send_text("LEN:99999999999\n");         // saturated accumulator
      send_text("LEN:-99999999\n");           // saturated and negative
      send_text("LEN:007\n");                 // leading zeros
      finish_frame();
      // header length exactly at header_limit, then one below it
      send_text("LEN:");
      repeat (95) send_byte(" ");
      send_text("1\n");
      send_text("LEN:");
      repeat (94) send_byte(" ");
      send_text("1\n");
      finish_frame();
      // payload cap changed while a header is half parsed: the pinned
      // count from the old limit is judged against the new one
      settle();
      write_csr(lpd_pkg::REG_PAYLOAD_CAP, 16'd20);
      send_text("LEN:999");
      settle();
      write_csr(lpd_pkg::REG_PAYLOAD_CAP, 16'hFFFF);
      send_text("\n");
      finish_frame();

      // random traffic over several register settings, extremes included
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin
               max_len = lpd_pkg::PAYLOAD_CAP_RESET;
               limit   = lpd_pkg::HEADER_LIMIT_RESET;
            end
            1: begin max_len = 16'd0;             limit = 8'd5;               end
            2: begin max_len = 16'hFFFF;          limit = 8'd255;             end
            3: begin max_len = 16'd12;            limit = 8'd16;              end
            4: begin max_len = 16'd300;           limit = 8'd40;              end
            default: begin
               max_len = 16'($urandom_range(1, 400));
               limit   = 8'($urandom_range(5, 255));
            end
         endcase
         configure(max_len, limit);
         if (p == 4) write_csr(REG_UNUSED, 16'($urandom_range(0, 65535)));
         calm = (p == 3);
         if (p % 2 == 0) hold_output = 1'b1;
         mark = byte_count;
         while (byte_count - mark < RANDOM_PHASE_BYTES) random_frame();
      end

      settle();
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin : watchdog
      #(CLOCK_PERIOD * RUN_LIMIT_CYCLES);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/lpd_pkg.sv
hdl/lpd_parse.sv
hdl/lpd_out_reg.sv
hdl/length_prefixed_deframer.sv
hdl/lpd_checker.sv
sim/tb_length_prefixed_deframer.sv
